// ===== sv/bois_pkg.sv =====
// Shared types and constants for the box overlap index search.
// No dependencies.
package bois_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam int unsigned MaxResults = 32;
  localparam logic [1:0] AddrRank = 2'd0;

  // one result word
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [1:0][31:0] file_rel;
    logic [1:0][31:0] stored;
    logic [1:0][31:0] mem_rel;
    logic [1:0][31:0] cnt;
    logic [62:0]      file_off;
    logic [62:0]      mem_off;
  } result_t;

endpackage

// ===== sv/bois_cell.sv =====
// One table entry of the rotating box chain.
// Depends on nothing; instantiated by box_overlap_index_search.
module bois_cell #(
  parameter int unsigned ND = 2
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic                 load_i,
  input  logic [ND-1:0][31:0]  nb_start_i,
  input  logic [ND-1:0][31:0]  nb_ext_i,
  input  logic [62:0]          nb_off_i,
  input  logic [ND-1:0][31:0]  ld_start_i,
  input  logic [ND-1:0][31:0]  ld_ext_i,
  input  logic [62:0]          ld_off_i,
  output logic [ND-1:0][31:0]  start_o,
  output logic [ND-1:0][31:0]  ext_o,
  output logic [62:0]          off_o
);
  logic [ND-1:0][31:0] start_q, ext_q;
  logic [62:0]         off_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      start_q <= nb_start_i;
      ext_q   <= nb_ext_i;
      off_q   <= nb_off_i;
    end else if (load_i) begin
      start_q <= ld_start_i;
      ext_q   <= ld_ext_i;
      off_q   <= ld_off_i;
    end
  end

  assign start_o = start_q;
  assign ext_o   = ext_q;
  assign off_o   = off_q;
endmodule

// ===== sv/bois_match.sv =====
// Overlap test of the head entry against the selection box.
// Uses bois_pkg for the result word.
module bois_match import bois_pkg::*; (
  input  logic [1:0][31:0] ent_start_i,
  input  logic [1:0][31:0] ent_ext_i,
  input  logic [1:0][31:0] sel_start_i,
  input  logic [1:0][31:0] sel_cnt_i,
  input  logic             use2_i,
  input  logic [62:0]      file_off_i,
  input  logic [62:0]      mem_off_i,
  output logic             ok_o,
  output result_t          res_o
);
  logic [1:0][32:0] ea, eb, hi;
  logic [1:0][31:0] lo;
  logic [1:0]       ov;

  always_comb begin
    res_o = '0;
    for (int d = 0; d < 2; d++) begin
      ea[d] = {1'b0, ent_start_i[d]} + {1'b0, ent_ext_i[d]};
      eb[d] = {1'b0, sel_start_i[d]} + {1'b0, sel_cnt_i[d]};
      lo[d] = (ent_start_i[d] > sel_start_i[d]) ? ent_start_i[d] : sel_start_i[d];
      hi[d] = (ea[d] < eb[d]) ? ea[d] : eb[d];
      ov[d] = hi[d] > {1'b0, lo[d]};
    end
    // dimension one only counts when the rank covers it
    ok_o = ov[0] && (ov[1] || !use2_i);
    res_o.hit = 1'b1;
    for (int d = 0; d < 2; d++) begin
      if (d == 0 || use2_i) begin
        res_o.file_rel[d] = lo[d] - ent_start_i[d];
        res_o.stored[d]   = ent_ext_i[d];
        res_o.mem_rel[d]  = lo[d] - sel_start_i[d];
        res_o.cnt[d]      = hi[d][31:0] - lo[d];
      end
    end
    res_o.file_off = file_off_i;
    res_o.mem_off  = mem_off_i;
  end
endmodule

// ===== sv/box_overlap_index_search.sv =====
// Top level: box table held in a rotating chain of cells, query scanner.
// Depends on bois_pkg, bois_cell, bois_match.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  request   | start, busy          | req_type_i, box_*, offsets, sel_*
//  result    | res_strobe_o (1 cyc) | hit_o, last_o, rel/size/count, offsets
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// Insert and clear complete at acceptance and do not raise busy. A query
// scans the table: the chain rotates once past the compare unit, one entry
// per cycle, then the held final word goes out. A hit word is held until the
// next hit, so a word trails its entry; the last word is registered from the
// ST_FIN state after the scan ends. The receiver cannot stall.
// Reset empties the table and zeroes the running offset; no clearing pass.
module box_overlap_index_search import bois_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_DIMS    = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] box_start0_i,
  input  logic [31:0] box_start1_i,
  input  logic [31:0] box_count0_i,
  input  logic [31:0] box_count1_i,
  input  logic [62:0] file_offset_i,
  input  logic [62:0] buf_base_i,
  input  logic [31:0] sel_size_i,
  input  logic        first_sel_i,
  output logic        res_strobe_o,
  output logic        hit_o,
  output logic        last_o,
  output logic [31:0] file_rel_start0_o,
  output logic [31:0] file_rel_start1_o,
  output logic [31:0] stored_size0_o,
  output logic [31:0] stored_size1_o,
  output logic [31:0] mem_rel_start0_o,
  output logic [31:0] mem_rel_start1_o,
  output logic [31:0] overlap_count0_o,
  output logic [31:0] overlap_count1_o,
  output logic [62:0] out_file_offset_o,
  output logic [62:0] out_mem_offset_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_e;

  state_e           state_q;
  logic [1:0]       rank_q;
  logic [UW-1:0]    used_q;
  logic [IW-1:0]    k_q;
  logic [NW-1:0]    nres_q;
  logic [63:0]      run_q;
  logic [1:0][31:0] sel_start_q, sel_cnt_q;
  logic [62:0]      mem_off_q;
  logic             use2_q;
  logic             pend_v_q;
  result_t          pend_q, out_q;
  logic             strobe_q;
  result_t          fin_w;

  logic [TABLE_DEPTH-1:0][MAX_DIMS-1:0][31:0] c_start, c_ext;
  logic [TABLE_DEPTH-1:0][62:0]               c_off;
  logic [MAX_DIMS-1:0][31:0] ld_start, ld_ext;
  logic accept, do_ins, shift;
  logic [63:0] run_base;

  assign accept = start && !busy;
  assign do_ins = accept && (req_type_i == REQ_INSERT) && (used_q < UW'(TABLE_DEPTH));
  assign shift  = (state_q == ST_SCAN);
  assign busy   = (state_q != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = {30'd0, rank_q};

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      ld_start[d] = (d == 0) ? box_start0_i : box_start1_i;
      ld_ext[d]   = (d == 0) ? box_count0_i : box_count1_i;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int unsigned NX = (i + 1) % TABLE_DEPTH;
    bois_cell #(.ND(MAX_DIMS)) u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .load_i     (do_ins && (used_q[IW-1:0] == IW'(i))),
      .nb_start_i (c_start[NX]),
      .nb_ext_i   (c_ext[NX]),
      .nb_off_i   (c_off[NX]),
      .ld_start_i (ld_start),
      .ld_ext_i   (ld_ext),
      .ld_off_i   (file_offset_i),
      .start_o    (c_start[i]),
      .ext_o      (c_ext[i]),
      .off_o      (c_off[i])
    );
  end

  logic [1:0][31:0] h_start, h_ext;
  logic             m_ok;
  result_t          m_res;

  assign h_start[0] = c_start[0][0];
  assign h_ext[0]   = c_ext[0][0];
  assign h_start[1] = (MAX_DIMS > 1) ? c_start[0][MAX_DIMS-1] : 32'd0;
  assign h_ext[1]   = (MAX_DIMS > 1) ? c_ext[0][MAX_DIMS-1] : 32'd0;

  bois_match u_match (
    .ent_start_i (h_start),
    .ent_ext_i   (h_ext),
    .sel_start_i (sel_start_q),
    .sel_cnt_i   (sel_cnt_q),
    .use2_i      (use2_q),
    .file_off_i  (c_off[0]),
    .mem_off_i   (mem_off_q),
    .ok_o        (m_ok),
    .res_o       (m_res)
  );

  logic hit_now;
  assign hit_now = m_ok && (UW'(k_q) < used_q) && (nres_q < NW'(MaxResults));
  assign run_base = first_sel_i ? 64'd0 : run_q;

  // final word: held hit, or the empty miss word
  always_comb begin
    fin_w      = pend_v_q ? pend_q : '0;
    fin_w.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rank_q      <= 2'd2;
      used_q      <= '0;
      run_q       <= '0;
      k_q         <= '0;
      nres_q      <= '0;
      pend_v_q    <= 1'b0;
      strobe_q    <= 1'b0;
      sel_start_q <= '0;
      sel_cnt_q   <= '0;
      mem_off_q   <= '0;
      use2_q      <= 1'b0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      strobe_q <= 1'b0;
      if (psel && penable && pwrite && paddr == AddrRank) rank_q <= pwdata[1:0];
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_INSERT: if (do_ins) used_q <= used_q + UW'(1);
              REQ_CLEAR:  used_q <= '0;
              REQ_QUERY: begin
                sel_start_q <= {box_start1_i, box_start0_i};
                sel_cnt_q   <= {box_count1_i, box_count0_i};
                use2_q      <= (rank_q >= 2'd2) && (MAX_DIMS > 1);
                mem_off_q   <= buf_base_i + run_base[62:0];
                run_q       <= run_base + {32'd0, sel_size_i};
                k_q         <= '0;
                nres_q      <= '0;
                pend_v_q    <= 1'b0;
                state_q     <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (hit_now) begin
            // the held word is not the last one: send it now
            if (pend_v_q) begin
              out_q    <= pend_q;
              strobe_q <= 1'b1;
            end
            pend_q   <= m_res;
            pend_v_q <= 1'b1;
            nres_q   <= nres_q + NW'(1);
          end
          k_q <= k_q + IW'(1);
          if (k_q == IW'(TABLE_DEPTH - 1)) state_q <= ST_FIN;
        end
        ST_FIN: begin
          out_q    <= fin_w;
          strobe_q <= 1'b1;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_strobe_o      = strobe_q;
  assign hit_o             = out_q.hit;
  assign last_o            = out_q.last;
  assign file_rel_start0_o = out_q.file_rel[0];
  assign file_rel_start1_o = out_q.file_rel[1];
  assign stored_size0_o    = out_q.stored[0];
  assign stored_size1_o    = out_q.stored[1];
  assign mem_rel_start0_o  = out_q.mem_rel[0];
  assign mem_rel_start1_o  = out_q.mem_rel[1];
  assign overlap_count0_o  = out_q.cnt[0];
  assign overlap_count1_o  = out_q.cnt[1];
  assign out_file_offset_o = out_q.file_off;
  assign out_mem_offset_o  = out_q.mem_off;
endmodule

// ===== sv/bois_checker.sv =====
// Port-level assertions for box_overlap_index_search, with its bind.
// Depends on bois_pkg.
module bois_checker import bois_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  req_type_i,
  input logic        res_strobe_o,
  input logic        hit_o,
  input logic        last_o,
  input logic [31:0] overlap_count0_o
);
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i == REQ_QUERY |=> busy)
    else $error("query did not raise busy");
  a_miss_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !hit_o |-> last_o)
    else $error("miss word without last");
  a_hit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && hit_o |-> overlap_count0_o != 32'd0)
    else $error("hit with empty overlap");
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |=> !res_strobe_o)
    else $error("word right after last");
endmodule

bind box_overlap_index_search bois_checker u_bois_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .req_type_i       (req_type_i),
  .res_strobe_o     (res_strobe_o),
  .hit_o            (hit_o),
  .last_o           (last_o),
  .overlap_count0_o (overlap_count0_o)
);

// ===== tb/sv/box_overlap_index_search_test.sv =====
// Testbench for box_overlap_index_search: directed table, then random requests,
// each result word checked against a behavioral model of the box table.
// Depends on bois_pkg and the box_overlap_index_search RTL.
module box_overlap_index_search_test import bois_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 32;
  localparam logic [62:0] Mask63 = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned CycleLimit = 900000;

  typedef struct {
    req_e            kind;
    logic [1:0][31:0] st;
    logic [1:0][31:0] ct;
    logic [62:0]     foff;
    logic [62:0]     base;
    logic [31:0]     size;
    logic            first;
  } request_t;

  // directed row: request plus optional typed-in expected single word
  typedef struct {
    request_t req;
    logic     fixed;
    result_t  want;
  } row_t;

  logic clk_i, rst_ni;
  logic start, busy;
  logic [1:0] req_type_i;
  logic [31:0] box_start0_i, box_start1_i, box_count0_i, box_count1_i;
  logic [62:0] file_offset_i, buf_base_i;
  logic [31:0] sel_size_i;
  logic first_sel_i;
  logic res_strobe_o, hit_o, last_o;
  logic [31:0] file_rel_start0_o, file_rel_start1_o, stored_size0_o, stored_size1_o;
  logic [31:0] mem_rel_start0_o, mem_rel_start1_o, overlap_count0_o, overlap_count1_o;
  logic [62:0] out_file_offset_o, out_mem_offset_o;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  box_overlap_index_search i_dut (.*);

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // model state
  logic [1:0][31:0] tbl_start [Depth];
  logic [1:0][31:0] tbl_count [Depth];
  logic [62:0]      tbl_foff [Depth];
  int unsigned      tbl_used;
  logic [63:0]      run_off;
  logic [1:0]       rank_reg;

  result_t pending_words[$];
  int unsigned mismatches, cycles;
  int unsigned send_idle;
  logic done;

  row_t rows[$];
  result_t nohit;

  function automatic int unsigned rank_eff();
    if (rank_reg == 2'd0) return 1;
    if (rank_reg > 2'd2) return 2;
    return int'(rank_reg);
  endfunction

  task automatic add_row(input row_t x);
    rows.insert(rows.size(), x);
  endtask

  // apply one request to the model, queue the words it produces
  task automatic search_predict(input request_t r);
    result_t w;
    int unsigned n, rk;
    logic ok;
    logic [32:0] lo, hi, ea, eb;
    n = 0;
    case (r.kind)
      REQ_INSERT: begin
        if (tbl_used < Depth) begin
          tbl_start[tbl_used] = r.st;
          tbl_count[tbl_used] = r.ct;
          tbl_foff[tbl_used] = r.foff;
          tbl_used++;
        end
      end
      REQ_CLEAR: tbl_used = 0;
      REQ_QUERY: begin
        if (r.first) run_off = '0;
        rk = rank_eff();
        for (int e = 0; e < tbl_used && n < MaxResults; e++) begin
          w = '0;
          ok = 1'b1;
          for (int d = 0; d < rk; d++) begin
            ea = {1'b0, tbl_start[e][d]} + tbl_count[e][d];
            eb = {1'b0, r.st[d]} + r.ct[d];
            lo = (tbl_start[e][d] > r.st[d]) ? {1'b0, tbl_start[e][d]} : {1'b0, r.st[d]};
            hi = (ea < eb) ? ea : eb;
            if (hi <= lo) ok = 1'b0;
            else begin
              w.file_rel[d] = 32'(lo - tbl_start[e][d]);
              w.stored[d] = tbl_count[e][d];
              w.mem_rel[d] = 32'(lo - r.st[d]);
              w.cnt[d] = 32'(hi - lo);
            end
          end
          if (ok) begin
            w.hit = 1'b1;
            w.file_off = tbl_foff[e];
            w.mem_off = 63'(64'(r.base) + run_off);
            pending_words.insert(pending_words.size(), w);
            n++;
          end
        end
        if (n == 0) pending_words.insert(pending_words.size(), result_t'('0));
        pending_words[$].last = 1'b1;
        run_off += r.size;
      end
      default: ;
    endcase
  endtask

  // start stays high after acceptance until the next idle cycle or drain
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= r.kind;
    box_start0_i <= r.st[0];
    box_start1_i <= r.st[1];
    box_count0_i <= r.ct[0];
    box_count1_i <= r.ct[1];
    file_offset_i <= r.foff;
    buf_base_i <= r.base;
    sel_size_i <= r.size;
    first_sel_i <= r.first;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    search_predict(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
  endtask

  task automatic write_rank(input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrRank; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rank_reg = v[1:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && res_strobe_o) begin
      got = '0;
      got.hit = hit_o; got.last = last_o;
      got.file_rel = {file_rel_start1_o, file_rel_start0_o};
      got.stored = {stored_size1_o, stored_size0_o};
      got.mem_rel = {mem_rel_start1_o, mem_rel_start0_o};
      got.cnt = {overlap_count1_o, overlap_count0_o};
      got.file_off = out_file_offset_o;
      got.mem_off = out_mem_offset_o;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch\n exp %p\n got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_coord(input logic wide);
    if (wide) return $urandom();
    return $urandom_range(60);
  endfunction

  function automatic request_t rnd_box(input req_e k, input logic wide);
    request_t r;
    r.kind = k;
    for (int d = 0; d < 2; d++) begin
      r.st[d] = rnd_coord(wide);
      r.ct[d] = wide ? $urandom() : $urandom_range(30);
    end
    r.foff = 63'({$urandom(), $urandom()});
    r.base = 63'({$urandom(), $urandom()});
    r.size = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4096);
    r.first = ($urandom_range(3) == 0);
    return r;
  endfunction

  function automatic request_t mk(input req_e k, input logic [31:0] s0, s1, c0, c1,
                                  input logic [62:0] fo, bb, input logic [31:0] sz,
                                  input logic fs);
    request_t r;
    r.kind = k; r.st = {s1, s0}; r.ct = {c1, c0};
    r.foff = fo; r.base = bb; r.size = sz; r.first = fs;
    return r;
  endfunction

  initial begin
    row_t rw;
    request_t r;
    rst_ni = 1'b0;
    start = 1'b0; req_type_i = REQ_NONE;
    box_start0_i = '0; box_start1_i = '0; box_count0_i = '0; box_count1_i = '0;
    file_offset_i = '0; buf_base_i = '0; sel_size_i = '0; first_sel_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = AddrRank; pwdata = '0;
    tbl_used = 0; run_off = '0; rank_reg = 2'd2;
    mismatches = 0; cycles = 0; send_idle = 25;
    nohit = '0; nohit.last = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty query, zero counts, max extremes, unused code, full table
    rw.fixed = 1'b1; rw.want = nohit;
    rw.req = mk(REQ_QUERY, 0, 0, 5, 5, 63'd0, Mask63, 32'hFFFF_FFFF, 1'b1); add_row(rw);
    rw.fixed = 1'b0;
    rw.req = mk(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                Mask63, 63'd0, 0, 1'b0); add_row(rw);
    rw.req = mk(REQ_INSERT, 0, 0, 0, 10, 63'd1, 63'd0, 0, 1'b0); add_row(rw);
    rw.req = mk(REQ_INSERT, 10, 10, 10, 10, 63'd2, 63'd0, 0, 1'b0); add_row(rw);
    rw.req = mk(REQ_NONE, 1, 1, 1, 1, 63'd3, 63'd3, 3, 1'b1); add_row(rw);
    rw.req = mk(REQ_QUERY, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                63'd0, Mask63, 32'hFFFF_FFFF, 1'b0); add_row(rw);
    rw.req = mk(REQ_QUERY, 15, 20, 1, 1, 63'd0, 63'd100, 8, 1'b0); add_row(rw);
    rw.req = mk(REQ_QUERY, 20, 0, 5, 5, 63'd0, 63'd100, 8, 1'b0); add_row(rw); // touching ends
    rw.req = mk(REQ_QUERY, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'd0, 63'd7, 1, 1'b1);
    add_row(rw);
    rw.req = mk(REQ_CLEAR, 0, 0, 0, 0, 63'd0, 63'd0, 0, 1'b0); add_row(rw);
    rw.fixed = 1'b1;
    rw.req = mk(REQ_QUERY, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'd0, 63'd0, 0, 1'b0);
    add_row(rw);
    rw.fixed = 1'b0;
    for (int i = 0; i < 34; i++) begin  // fill past capacity, then one query spanning all stored boxes
      if (i == 0) rw.req = mk(REQ_INSERT, 0, 0, 100, 100, 63'd9, 63'd0, 0, 1'b0);
      else rw.req = rnd_box(REQ_INSERT, 1'b0);
      if (i < 12 || i > 31) add_row(rw);
      else begin
        rw.req.st = '0; rw.req.ct = {32'd50, 32'd50}; add_row(rw);
      end
    end
    rw.req = mk(REQ_QUERY, 0, 0, 200, 200, 63'd0, 63'd5, 9, 1'b1); add_row(rw);

    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].fixed && pending_words.size() == 1 &&
          pending_words[0] !== rows[i].want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("directed row %0d\n exp %p\n got %p", i, rows[i].want, pending_words[0]);
        end
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_rank(ph == 0 ? 32'd1 : ph == 1 ? 32'd0 : ph == 2 ? 32'd3 : 32'd2);
      send_idle = (ph == 0) ? 25 : (ph == 1) ? 83 : 0;
      for (int i = 0; i < 110; i++) begin
        case ($urandom_range(19))
          0: r = rnd_box(REQ_CLEAR, 1'b0);
          1: r = rnd_box(REQ_NONE, 1'b1);
          2, 3, 4, 5, 6, 7, 8: r = rnd_box(REQ_INSERT, $urandom_range(9) == 0);
          default: r = rnd_box(REQ_QUERY, $urandom_range(9) == 0);
        endcase
        if (ph == 3 && i > 60 && $urandom_range(1)) begin
          start <= 1'b0;
          repeat (1 + $urandom_range(40)) @(posedge clk_i);
        end
        send_request(r);
      end
      drain();
    end

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
